// ===== rtl/periodic_task_timer_table_assert.svh =====
// Assertion macros for the task timer table.
// No dependencies.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
// a implies b in the next cycle
`define PTT_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("ptt assertion failed");
// a implies b in the same cycle
`define PTT_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("ptt assertion failed");
`endif

// ===== rtl/ptt_pkg.sv =====
// Package of the task timer table: types, constants, cell record.
// No dependencies.
package ptt_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned MaxRes = 16;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0, ACT_ADD = 2'd1, ACT_REMOVE = 2'd2, ACT_DONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    K_DISPATCH = 3'd0, K_SKIP = 3'd1, K_ADDED = 3'd2, K_FULL = 3'd3,
    K_REMOVED = 3'd4, K_NOTFOUND = 3'd5, K_COMPLETED = 3'd6
  } kind_e;

  // Overrun handling while a task is still running.
  localparam logic [1:0] OVR_SHARE = 2'd0;
  localparam logic [1:0] OVR_SKIP = 2'd1;
  localparam logic [1:0] OVR_HOLD = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] task_id;
    logic [31:0] span_ms;
    logic        periodic;
    logic [1:0]  policy;
    logic        run_now;
    logic        inline_run;
    logic        urgent;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_id;
    logic [3:0]  slot_index;
    logic        urgent_out;
    logic        inline_out;
    logic        last;
  } out_req_t;

  // One table entry as it travels around the ring.
  typedef struct packed {
    logic        used;
    logic        active;
    logic        periodic;
    logic [1:0]  policy;
    logic        inl;
    logic        urg;
    logic [31:0] id;
    logic [47:0] deadline;
    logic [31:0] period;
    logic [7:0]  running;
  } slot_t;
endpackage

// ===== rtl/ptt_cell.sv =====
// One cell of the slot ring: holds an entry, passes it on when shifting.
// Depends on ptt_pkg.
module ptt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  ptt_pkg::slot_t prev_i,
  output ptt_pkg::slot_t slot_o
);
  import ptt_pkg::*;
  slot_t slot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= prev_i;
    end
  end
  assign slot_o = slot_q;
endmodule

// ===== rtl/ptt_proc.sv =====
// Entry processor at the head of the ring: applies one request to one entry.
// Depends on ptt_pkg.
module ptt_proc (
  input  ptt_pkg::in_req_t req_i,
  input  ptt_pkg::slot_t   slot_i,
  input  logic [47:0]      now_i,
  input  logic [31:0]      nid_i,
  input  logic             taken_i,
  output ptt_pkg::slot_t   slot_o,
  output logic             emit_o,
  output logic             hit_o,
  output ptt_pkg::kind_e   kind_o,
  output logic             urg_o,
  output logic             inl_o
);
  import ptt_pkg::*;
  logic due, free, match;
  logic [47:0] rearm;
  always_comb begin
    slot_o = slot_i;
    emit_o = 1'b0;
    hit_o = 1'b0;
    kind_o = K_DISPATCH;
    urg_o = 1'b0;
    inl_o = 1'b0;
    due = slot_i.used && slot_i.active && !(slot_i.deadline > now_i);
    free = !slot_i.used || (!slot_i.active && slot_i.running == 8'd0);
    match = slot_i.used && slot_i.id == req_i.task_id;
    rearm = slot_i.deadline + {16'd0, slot_i.period};
    case (action_e'(req_i.action))
      ACT_TICK: begin
        if (due) begin
          if (slot_i.running != 8'd0 && slot_i.policy == OVR_SKIP) begin
            slot_o.deadline = rearm;
            emit_o = 1'b1;
            kind_o = K_SKIP;
          end else if (!(slot_i.running != 8'd0 && slot_i.policy == OVR_HOLD)) begin
            if (!slot_i.inl && slot_i.running != 8'hFF)
              slot_o.running = slot_i.running + 8'd1;
            emit_o = 1'b1;
            urg_o = slot_i.urg;
            inl_o = slot_i.inl;
            if (slot_i.periodic) slot_o.deadline = rearm;
            else slot_o.active = 1'b0;
          end
        end
      end
      ACT_ADD: begin
        if (free && !taken_i) begin
          hit_o = 1'b1;
          kind_o = K_ADDED;
          slot_o.used = 1'b1;
          slot_o.active = 1'b1;
          slot_o.id = nid_i;
          slot_o.running = 8'd0;
          slot_o.periodic = req_i.periodic;
          slot_o.urg = req_i.urgent;
          if (req_i.periodic) begin
            slot_o.deadline = req_i.run_now ? now_i : now_i + {16'd0, req_i.span_ms};
            slot_o.period = req_i.span_ms;
            slot_o.policy = req_i.policy;
            slot_o.inl = req_i.inline_run;
          end else begin
            slot_o.deadline = now_i + {16'd0, req_i.span_ms};
            slot_o.period = '0;
            slot_o.policy = OVR_SHARE;
            slot_o.inl = 1'b0;
          end
        end
      end
      ACT_REMOVE: begin
        if (match && !taken_i) begin
          hit_o = 1'b1;
          kind_o = K_REMOVED;
          slot_o.active = 1'b0;
        end
      end
      ACT_DONE: begin
        if (match && !taken_i) begin
          hit_o = 1'b1;
          kind_o = K_COMPLETED;
          if (slot_i.running != 8'd0) slot_o.running = slot_i.running - 8'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table: ring of slot cells and sequencer.
// Depends on ptt_pkg, ptt_cell, ptt_proc and the assertion header.
//
//  channel | direction | payload   | handshake
//  in      | into      | in_req_t  | in_valid_i / in_stall_o
//  out     | out of    | out_req_t | out_valid_o / out_stall_i
//
// Every request rotates the ring of Slots cells once, one entry per cycle
// while the ring is not halted, through the processor at its head: accept,
// ring lap, finish; a new request is taken only once the finish returns to idle.
// Ticks, adds, removes and completions all take one lap.
// Tick results go through a pending register, then a one-deep output register;
// the ring halts while a new result finds that register full and stalled, and
// the finish cycle repeats until the last result has moved out.
// Reset empties every cell at once.
module periodic_task_timer_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ptt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ptt_pkg::out_req_t out_req_o
);
  import ptt_pkg::*;
  `include "periodic_task_timer_table_assert.svh"

  state_e state_q, state_d;
  in_req_t req_q;
  logic [47:0] now_q;
  logic [31:0] nid_q;
  logic [SlotW-1:0] idx_q;        // slot number now at the head
  logic taken_q;                  // add/remove/done found its slot
  logic [SlotW-1:0] hit_idx_q;
  logic [4:0] cnt_q;              // results emitted this request
  out_req_t obuf_q, obuf_d;
  logic ovalid_q, ovalid_d;
  // tick results pass through pend until the next one or the lap end,
  // so the final one can still be marked last
  out_req_t pend_q, pend_d;
  logic pend_v_q, pend_v_d;

  slot_t cell_out [Slots];
  slot_t head_new;
  logic  shift;
  logic  emit, hit, urg, inl;
  kind_e kind;

  // Ring: the processed head entry is fed into the tail.
  for (genvar g = 0; g < Slots; g++) begin : g_ring
    ptt_cell u_cell (
      .clk_i, .rst_ni, .shift_i(shift),
      .prev_i(g == Slots - 1 ? head_new : cell_out[(g + 1) % Slots]),
      .slot_o(cell_out[g])
    );
  end

  ptt_proc u_proc (
    .req_i(req_q), .slot_i(cell_out[0]), .now_i(now_q), .nid_i(nid_q),
    .taken_i(taken_q), .slot_o(head_new), .emit_o(emit), .hit_o(hit),
    .kind_o(kind), .urg_o(urg), .inl_o(inl)
  );

  logic obuf_free;
  logic scan_emit;    // tick result ready to leave at this cycle
  logic last_slot;
  logic pend_push;
  logic is_tick;
  logic tick_fin_hold;  // last tick result still waits for the output register
  logic tick_fin_move;
  logic fin_emit;       // add/remove/done result enters the output register
  assign obuf_free = !ovalid_q || !out_stall_i;
  assign last_slot = idx_q == SlotW'(Slots - 1);
  assign is_tick = req_q.action == ACT_TICK;
  assign scan_emit = state_q == ST_SCAN && emit && cnt_q < 5'(MaxRes);
  // A pending result must land before the ring advances.
  assign shift = state_q == ST_SCAN && (!scan_emit || obuf_free);
  assign pend_push = scan_emit && shift && is_tick;
  assign tick_fin_hold = state_q == ST_FINISH && is_tick && pend_v_q && !obuf_free;
  assign tick_fin_move = state_q == ST_FINISH && is_tick && pend_v_q && obuf_free;
  assign fin_emit = state_q == ST_FINISH && !is_tick && obuf_free;
  assign in_stall_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (shift && last_slot) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (is_tick) begin
          if (!tick_fin_hold) state_d = ST_IDLE;
        end else if (obuf_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output path: pending tick result, output register, lap-end result.
  always_comb begin
    ovalid_d = ovalid_q && out_stall_i;
    obuf_d = obuf_q;
    pend_d = pend_q;
    pend_v_d = pend_v_q;
    if (pend_push) begin
      // previous pending result moves to the output register
      if (pend_v_q) begin
        obuf_d = pend_q;
        ovalid_d = 1'b1;
      end
      pend_d = '0;
      pend_d.kind = kind;
      pend_d.result_id = cell_out[0].id;
      pend_d.slot_index = 4'(idx_q);
      pend_d.urgent_out = urg;
      pend_d.inline_out = inl;
      pend_v_d = 1'b1;
    end
    if (tick_fin_move) begin
      obuf_d = pend_q;
      obuf_d.last = 1'b1;
      ovalid_d = 1'b1;
      pend_v_d = 1'b0;
    end
    if (fin_emit) begin
      obuf_d = '0;
      obuf_d.last = 1'b1;
      ovalid_d = 1'b1;
      if (taken_q) obuf_d.slot_index = 4'(hit_idx_q);
      case (action_e'(req_q.action))
        ACT_ADD: begin
          obuf_d.kind = taken_q ? K_ADDED : K_FULL;
          obuf_d.result_id = taken_q ? nid_q : 32'd0;
        end
        ACT_REMOVE: begin
          obuf_d.kind = taken_q ? K_REMOVED : K_NOTFOUND;
          obuf_d.result_id = req_q.task_id;
        end
        ACT_DONE: begin
          obuf_d.kind = taken_q ? K_COMPLETED : K_NOTFOUND;
          obuf_d.result_id = req_q.task_id;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      now_q <= '0;
      nid_q <= 32'd1;
      obuf_q <= '0;
      ovalid_q <= 1'b0;
      pend_q <= '0;
      pend_v_q <= 1'b0;
      idx_q <= '0;
      taken_q <= 1'b0;
      cnt_q <= '0;
      hit_idx_q <= '0;
    end else begin
      obuf_q <= obuf_d;
      ovalid_q <= ovalid_d;
      pend_q <= pend_d;
      pend_v_q <= pend_v_d;
      if (state_q == ST_IDLE && in_valid_i) begin
        req_q <= in_req_i;
        idx_q <= '0;
        taken_q <= 1'b0;
        cnt_q <= '0;
        if (in_req_i.action == ACT_TICK) now_q <= now_q + 48'd1;
      end
      if (shift) begin
        idx_q <= idx_q + SlotW'(1);
        if (hit) begin
          taken_q <= 1'b1;
          hit_idx_q <= idx_q;
        end
        if (pend_push) cnt_q <= cnt_q + 5'd1;
      end
      // the id is used only when an add found a slot
      if (fin_emit && taken_q && req_q.action == ACT_ADD) nid_q <= nid_q + 32'd1;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_req_o = obuf_q;

  `PTT_ASSERT_NOW(a_no_shift_idle, state_q == ST_IDLE, !shift)
  `PTT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `PTT_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_req_o))
  `PTT_ASSERT_NOW(a_cnt_bound, state_q != ST_IDLE, cnt_q <= 5'(MaxRes))
endmodule

// ===== verif/tb_periodic_task_timer_table.sv =====
// Testbench of the periodic task timer table: directed and random requests,
// a scoreboard class that predicts every result, random input gaps and result stalls.
// Depends on ptt_pkg and the periodic_task_timer_table RTL.
module tb_periodic_task_timer_table;
  import ptt_pkg::*;

  // Expected-result store and table predictor.
  class timer_scoreboard;
    logic [47:0] now_ms;
    logic [31:0] next_id;
    slot_t       tbl[Slots];
    out_req_t    pending[$];
    int          errors;

    function new();
      now_ms  = '0;
      next_id = 32'd1;
      errors  = 0;
      foreach (tbl[i]) tbl[i] = '0;
    endfunction

    function void push(kind_e k, logic [31:0] id, int s, logic u, logic l);
      out_req_t r;
      r = '0;
      r.kind = k;
      r.result_id = id;
      r.slot_index = s[3:0];
      r.urgent_out = u;
      r.inline_out = l;
      pending.push_back(r);
    endfunction

    // Applies one accepted request to the predicted table.
    function void note_request(in_req_t q);
      int n0, s;
      n0 = pending.size();
      s = -1;
      case (action_e'(q.action))
        ACT_TICK: begin
          now_ms = now_ms + 48'd1;
          for (int i = 0; i < Slots; i++) begin
            if (!tbl[i].used || !tbl[i].active || tbl[i].deadline > now_ms) continue;
            if (tbl[i].running != 0) begin
              if (tbl[i].policy == OVR_SKIP) begin
                tbl[i].deadline = tbl[i].deadline + {16'd0, tbl[i].period};
                push(K_SKIP, tbl[i].id, i, 1'b0, 1'b0);
                continue;
              end
              if (tbl[i].policy == OVR_HOLD) continue;
            end
            if (!tbl[i].inl && tbl[i].running != 8'd255)
              tbl[i].running = tbl[i].running + 8'd1;
            push(K_DISPATCH, tbl[i].id, i, tbl[i].urg, tbl[i].inl);
            if (tbl[i].periodic)
              tbl[i].deadline = tbl[i].deadline + {16'd0, tbl[i].period};
            else
              tbl[i].active = 1'b0;
          end
        end
        ACT_ADD: begin
          for (int i = 0; i < Slots; i++)
            if (!tbl[i].used || (!tbl[i].active && tbl[i].running == 0)) begin
              s = i;
              break;
            end
          if (s < 0) push(K_FULL, '0, 0, 1'b0, 1'b0);
          else begin
            tbl[s] = '0;
            tbl[s].used = 1'b1;
            tbl[s].active = 1'b1;
            tbl[s].id = next_id;
            tbl[s].periodic = q.periodic;
            tbl[s].urg = q.urgent;
            if (q.periodic) begin
              tbl[s].deadline = q.run_now ? now_ms : now_ms + {16'd0, q.span_ms};
              tbl[s].period = q.span_ms;
              tbl[s].policy = q.policy;
              tbl[s].inl = q.inline_run;
            end else begin
              tbl[s].deadline = now_ms + {16'd0, q.span_ms};
            end
            push(K_ADDED, next_id, s, 1'b0, 1'b0);
            next_id = next_id + 32'd1;
          end
        end
        default: begin
          for (int i = 0; i < Slots; i++)
            if (tbl[i].used && tbl[i].id == q.task_id) begin
              s = i;
              break;
            end
          if (s < 0) push(K_NOTFOUND, q.task_id, 0, 1'b0, 1'b0);
          else if (q.action == ACT_REMOVE) begin
            tbl[s].active = 1'b0;
            push(K_REMOVED, q.task_id, s, 1'b0, 1'b0);
          end else begin
            if (tbl[s].running != 0) tbl[s].running = tbl[s].running - 8'd1;
            push(K_COMPLETED, q.task_id, s, 1'b0, 1'b0);
          end
        end
      endcase
      if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_result(out_req_t got);
      out_req_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind || got.result_id !== exp.result_id ||
          got.slot_index !== exp.slot_index || got.urgent_out !== exp.urgent_out ||
          got.inline_out !== exp.inline_out || got.last !== exp.last) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  timer_scoreboard sb = new();
  int       cycle_count = 0;
  bit       hold_rx = 1'b0;   // long receiver hold-off requested by the sender
  bit       stall_quiet = 1'b0;

  localparam int unsigned CycleLimit = 4000000;

  periodic_task_timer_table dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o
  );

  always #10 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check on acceptance, random stall, long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_req_o);
  end

  initial begin : rx_stall
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        hold_rx = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_quiet) out_stall_i <= 1'b0;
      else if ($urandom_range(0, 99) < 3) begin
        out_stall_i <= 1'b1;
        hold = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else out_stall_i <= 1'b0;
    end
  end

  // Offers one request and waits until it is accepted; valid drops
  // after acceptance while the block works on the request.
  task automatic send_request(in_req_t q);
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(q);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int g;
    if (stall_quiet) return;
    g = $urandom_range(0, 99);
    if (g < 60) return;
    g = (g < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80);
    repeat (g) @(posedge clk_i);
  endtask

  // Random request: mostly ticks and well-formed adds with small intervals,
  // completions and removes aimed at recently issued ids, some noise ids.
  function automatic in_req_t random_request();
    in_req_t q;
    int r;
    q = '0;
    q.task_id     = $urandom();
    q.span_ms     = $urandom();
    q.periodic    = 1'($urandom_range(0, 1));
    q.policy      = 2'($urandom_range(0, 3));
    q.run_now     = 1'($urandom_range(0, 1));
    q.inline_run  = 1'($urandom_range(0, 1));
    q.urgent      = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 45) q.action = ACT_TICK;
    else if (r < 65) begin
      q.action = ACT_ADD;
      if ($urandom_range(0, 9) != 0) q.span_ms = $urandom_range(0, 6);
    end else begin
      q.action = (r < 85) ? ACT_DONE : ACT_REMOVE;
      if ($urandom_range(0, 7) != 0)
        q.task_id = sb.next_id - 32'($urandom_range(1, 20));
    end
    return q;
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_req_t q;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every action, special cases.
    stall_quiet = 1'b1;
    q = '0;
    q.action = ACT_TICK;                                  send_request(q);  // nothing due
    q.action = ACT_DONE; q.task_id = 32'hFFFF_FFFF;       send_request(q);  // not found
    q.action = ACT_REMOVE; q.task_id = 32'd0;             send_request(q);
    // periodic run_now, each policy incl. the unknown one, inline/urgent mix
    for (int p = 0; p < 4; p++) begin
      q = '0; q.action = ACT_ADD; q.periodic = 1'b1; q.run_now = 1'b1;
      q.policy = p[1:0]; q.span_ms = 32'd1; q.urgent = p[0]; q.inline_run = p[1];
      send_request(q);
    end
    q = '0; q.action = ACT_ADD; q.span_ms = 32'hFFFF_FFFF; q.policy = 2'd3;
    q.inline_run = 1'b1; q.urgent = 1'b1;                 send_request(q);  // one-shot far
    q = '0; q.action = ACT_ADD; q.span_ms = 32'd0;        send_request(q);  // one-shot now
    q = '0; q.action = ACT_TICK;
    repeat (3) send_request(q);                           // overrun skip/wait/overlap
    q.action = ACT_DONE; q.task_id = 32'd2;
    repeat (2) send_request(q);                           // completion down to zero
    q.action = ACT_REMOVE; q.task_id = 32'd1;             send_request(q);
    // fill the table and overflow it
    q = '0; q.action = ACT_ADD; q.span_ms = 32'd100;
    repeat (12) send_request(q);
    q.periodic = 1'b1; q.span_ms = 32'hFFFF_FFFF;         send_request(q);
    drain();

    // Receiver holds off long while requests keep coming.
    stall_quiet = 1'b0;
    hold_rx = 1'b1;
    for (int n = 0; n < 400; n++) begin
      send_request(random_request());
      idle_gap();
      if (n == 200) drain();                              // sender waits for all
      // clean up periodically so new adds find free slots
      if (n % 60 == 59) begin
        for (int k = 0; k < 16; k++) begin
          q = '0; q.action = ACT_REMOVE; q.task_id = sb.tbl[k].id;
          if (sb.tbl[k].used && sb.tbl[k].active) send_request(q);
        end
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== periodic_task_timer_table.f =====
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_cell.sv
rtl/ptt_proc.sv
rtl/periodic_task_timer_table.sv
verif/tb_periodic_task_timer_table.sv
